>>> design/timed_motor_pulse_sequencer_top_defines.svh
// Assertion macros shared by the checker of the motor pulse sequencer.
`ifndef TIMED_MOTOR_PULSE_SEQUENCER_TOP_DEFINES_SVH
`define TIMED_MOTOR_PULSE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tmps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tmps assertion failed");

`endif

>>> design/tmps_pkg.sv
// Types and codes shared by the motor pulse sequencer.
`default_nettype none
package tmps_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PSTART  = 2'd1,
		OP_NPSTART = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DRIVE = 2'd1,
		PH_COOL  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] duty;
		logic        turn_reverse;
		logic [15:0] drive_ms;
		logic [15:0] rest_ms;
		logic [15:0] elapsed;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic               apply_drive;
		logic               brake_now;
		logic [15:0]        duty_out;
		logic               dir_out;
		logic signed [15:0] position;
		logic               waiting;
	} out_word_t;

endpackage
`default_nettype wire

>>> design/tmps_if.sv
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface tmps_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] duty;
	logic        turn_reverse;
	logic [15:0] drive_ms;
	logic [15:0] rest_ms;
	logic [15:0] elapsed;

	modport source (output valid, opcode, duty, turn_reverse, drive_ms, rest_ms, elapsed,
		input ready);
	modport sink (input valid, opcode, duty, turn_reverse, drive_ms, rest_ms, elapsed,
		output ready);
endinterface

interface tmps_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         phase;
	logic               apply_drive;
	logic               brake_now;
	logic [15:0]        duty_out;
	logic               dir_out;
	logic signed [15:0] position;
	logic               waiting;

	modport source (output valid, phase, apply_drive, brake_now, duty_out, dir_out,
		position, waiting, input ready);
	modport sink (input valid, phase, apply_drive, brake_now, duty_out, dir_out,
		position, waiting, output ready);
endinterface
`default_nettype wire

>>> design/tmps_core.sv
// Sequencer state and its single-pass update for one word.
`default_nettype none
module tmps_core #(
	parameter int TIME_BITS     = 16,
	parameter int POSITION_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire tmps_pkg::in_word_t word,
	output tmps_pkg::out_word_t     res
);
	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam int SUM_W = CMP_W + 1;
	localparam logic [TIME_BITS-1:0] TIMER_TOP = '1;

	tmps_pkg::phase_t         phase_q, phase_n;
	logic [TIME_BITS-1:0]     timer_q, timer_n, timer_sat;
	logic                     pending_q, pending_n;
	logic [15:0]              duty_q, duty_n;
	logic                     rev_q, rev_n;
	logic [15:0]              drv_lim_q, drv_lim_n;
	logic [15:0]              rst_lim_q, rst_lim_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [SUM_W-1:0]         timer_sum;
	logic                     apply, brake;
	logic signed [31:0]       pos_ext;

	// saturating timer add shared by both timed phases
	always_comb begin
		timer_sum = SUM_W'(timer_q) + SUM_W'(word.elapsed);
		timer_sat = (timer_sum > SUM_W'(TIMER_TOP)) ? TIMER_TOP : timer_sum[TIME_BITS-1:0];
	end

	always_comb begin
		phase_n   = phase_q;
		timer_n   = timer_q;
		pending_n = pending_q;
		duty_n    = duty_q;
		rev_n     = rev_q;
		drv_lim_n = drv_lim_q;
		rst_lim_n = rst_lim_q;
		pos_n     = pos_q;
		apply     = 1'b0;
		brake     = 1'b0;
		case (tmps_pkg::opcode_t'(word.opcode))
			tmps_pkg::OP_TICK: begin
				case (phase_q)
					tmps_pkg::PH_IDLE: begin
						if (pending_q) begin
							apply     = 1'b1;
							phase_n   = tmps_pkg::PH_DRIVE;
							timer_n   = '0;
							pending_n = 1'b0;
						end
					end
					tmps_pkg::PH_DRIVE: begin
						timer_n = timer_sat;
						if (CMP_W'(timer_sat) >= CMP_W'(drv_lim_q)) begin
							brake   = 1'b1;
							phase_n = tmps_pkg::PH_COOL;
							timer_n = '0;
						end
					end
					tmps_pkg::PH_COOL: begin
						timer_n = timer_sat;
						if (CMP_W'(timer_sat) >= CMP_W'(rst_lim_q)) begin
							phase_n = tmps_pkg::PH_IDLE;
							timer_n = '0;
						end
					end
					default: ;
				endcase
			end
			tmps_pkg::OP_PSTART: begin
				case (phase_q)
					tmps_pkg::PH_IDLE: begin
						pending_n = 1'b1;
						timer_n   = '0;
						duty_n    = word.duty;
						rev_n     = word.turn_reverse;
						drv_lim_n = word.drive_ms;
						rst_lim_n = word.rest_ms;
					end
					tmps_pkg::PH_DRIVE: begin
						duty_n    = word.duty;
						rev_n     = word.turn_reverse;
						drv_lim_n = word.drive_ms;
						rst_lim_n = word.rest_ms;
						timer_n   = '0;
						if (rev_q == word.turn_reverse) begin
							apply = 1'b1;
						end else begin
							brake     = 1'b1;
							phase_n   = tmps_pkg::PH_COOL;
							pending_n = 1'b1;
						end
					end
					default: ;
				endcase
			end
			tmps_pkg::OP_NPSTART: begin
				if (phase_q == tmps_pkg::PH_IDLE) begin
					pending_n = 1'b1;
					timer_n   = '0;
					duty_n    = word.duty;
					rev_n     = word.turn_reverse;
					drv_lim_n = word.drive_ms;
					rst_lim_n = word.rest_ms;
					pos_n     = word.turn_reverse ? pos_q - POSITION_BITS'(1)
						: pos_q + POSITION_BITS'(1);
				end
			end
			tmps_pkg::OP_CLEAR: begin
				pos_n = '0;
			end
			default: ;
		endcase
	end

	// sign-extend the step count, then cut to the port width
	assign pos_ext = 32'(signed'(pos_n));

	always_comb begin
		res.phase       = phase_n;
		res.apply_drive = apply;
		res.brake_now   = brake;
		res.duty_out    = duty_n;
		res.dir_out     = rev_n;
		res.position    = pos_ext[15:0];
		res.waiting     = pending_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tmps_pkg::PH_IDLE;
			timer_q   <= '0;
			pending_q <= 1'b0;
			duty_q    <= '0;
			rev_q     <= 1'b0;
			drv_lim_q <= '0;
			rst_lim_q <= '0;
			pos_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			timer_q   <= timer_n;
			pending_q <= pending_n;
			duty_q    <= duty_n;
			rev_q     <= rev_n;
			drv_lim_q <= drv_lim_n;
			rst_lim_q <= rst_lim_n;
			pos_q     <= pos_n;
		end
	end
endmodule
`default_nettype wire

>>> design/timed_motor_pulse_sequencer_top.sv
// Top level of the timed motor pulse sequencer.
// The sequencer takes one request word per clock while the result side is
// not stalled and returns one result word for each. A word is captured in an
// input register; once the result register is free or being read, the phase
// logic (one saturating timer add and compare, one step counter add) updates
// the sequencer state and the result is captured in the output register.
// Sustained rate is one word per cycle when not stalled, set by the state
// update. A stalled result register holds its word while the input
// register still takes one more, so the request side keeps moving until
// both stages are full. Timer width follows TIME_BITS (it saturates at its
// all-ones value); the step count is POSITION_BITS wide, wraps, and is shown
// sign-extended or cut to the 16-bit position field.
`default_nettype none
module timed_motor_pulse_sequencer_top #(
	parameter int TIME_BITS     = 16,
	parameter int POSITION_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tmps_req_if.sink   req,
	tmps_rsp_if.source rsp
);
	logic                valid_s1;
	tmps_pkg::in_word_t  word_s1;
	logic                valid_s2;
	tmps_pkg::out_word_t res_s2;
	tmps_pkg::out_word_t res_next;
	logic                advance;
	logic                take;

	// advance the held word into the result stage when that stage frees up
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || advance) begin
			valid_s1 <= take;
		end
	end

	// payload only: capture on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.opcode       <= req.opcode;
			word_s1.duty         <= req.duty;
			word_s1.turn_reverse <= req.turn_reverse;
			word_s1.drive_ms     <= req.drive_ms;
			word_s1.rest_ms      <= req.rest_ms;
			word_s1.elapsed      <= req.elapsed;
		end
	end

	// state update commits exactly when the word moves to the result stage
	tmps_core #(
		.TIME_BITS    (TIME_BITS),
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.word  (word_s1),
		.res   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	// drive the result channel from the output register
	assign rsp.valid       = valid_s2;
	assign rsp.phase       = res_s2.phase;
	assign rsp.apply_drive = res_s2.apply_drive;
	assign rsp.brake_now   = res_s2.brake_now;
	assign rsp.duty_out    = res_s2.duty_out;
	assign rsp.dir_out     = res_s2.dir_out;
	assign rsp.position    = res_s2.position;
	assign rsp.waiting     = res_s2.waiting;
endmodule
`default_nettype wire

>>> design/tmps_checker.sv
// Port-level checks of the motor pulse sequencer and their bind.
`default_nettype none
`include "timed_motor_pulse_sequencer_top_defines.svh"
module tmps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] rsp_phase,
	input wire logic       rsp_apply_drive,
	input wire logic       rsp_brake_now
);
	`TMPS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`TMPS_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !rsp_valid, req_ready)
	`TMPS_ASSERT_SAME(a_apply_brake_excl, clk, arst_n, rsp_valid, !(rsp_apply_drive && rsp_brake_now))
	`TMPS_ASSERT_SAME(a_apply_drives, clk, arst_n, rsp_valid && rsp_apply_drive, rsp_phase == tmps_pkg::PH_DRIVE)
	`TMPS_ASSERT_SAME(a_brake_cools, clk, arst_n, rsp_valid && rsp_brake_now, rsp_phase == tmps_pkg::PH_COOL)
endmodule

bind timed_motor_pulse_sequencer_top tmps_checker u_tmps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_phase      (rsp.phase),
	.rsp_apply_drive(rsp.apply_drive),
	.rsp_brake_now  (rsp.brake_now)
);
`default_nettype wire
